// File: src/ctld_pkg.sv
// Shared widths, register indexes and pipeline payload types for the cross-track distance unit.
`timescale 1ns / 1ps
package ctld_pkg;

    localparam int CRD_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int DIF_W     = CRD_W + 1;
    localparam int PRD_W     = 2 * DIF_W;
    localparam int SUM_W     = PRD_W + 1;
    localparam int ROOT_W    = 50;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int HQ_W      = 33;
    localparam int VQ_W      = 67;
    localparam int NMAG_W    = 98;
    localparam int NSUM_W    = NMAG_W + 2;
    localparam int REG_IDX_W = 3;
    localparam int IN_DATA_W = 3 * CRD_W;
    localparam int OUT_DATA_W = 2 * CRD_W;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_START_X = 3'd0,
        REG_START_Y = 3'd1,
        REG_START_Z = 3'd2,
        REG_END_X   = 3'd3,
        REG_END_Y   = 3'd4,
        REG_END_Z   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic              degen;
        logic              h_neg;
        logic [PRD_W-1:0]  h_mag;
        logic              n_neg;
        logic [NMAG_W-1:0] n_mag;
    } t_geo;

    typedef struct packed {
        logic              degen;
        logic              h_neg;
        logic [PRD_W-1:0]  h_mag;
        logic              n_neg;
        logic [ROOT_W-1:0] lq;
        logic [ROOT_W-1:0] lt;
    } t_vq_side;

    typedef struct packed {
        logic flag;
        logic neg;
    } t_tag;

endpackage

// File: src/ctld_front.sv
// Front pipeline: differences, products and exact numerators of both distances.
`timescale 1ns / 1ps
module ctld_front import ctld_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [CRD_W-1:0] i_pos_x,
    input  logic [CRD_W-1:0] i_pos_y,
    input  logic [CRD_W-1:0] i_pos_z,
    input  logic [CRD_W-1:0] i_start_x,
    input  logic [CRD_W-1:0] i_start_y,
    input  logic [CRD_W-1:0] i_start_z,
    input  logic [CRD_W-1:0] i_end_x,
    input  logic [CRD_W-1:0] i_end_y,
    input  logic [CRD_W-1:0] i_end_z,
    output logic             o_valid,
    output t_geo             o_geo,
    output logic [PRD_W-1:0] o_s,
    output logic [PRD_W-1:0] o_t
);

    typedef struct packed {
        logic             degen;
        logic             h_neg;
        logic [PRD_W-1:0] h_mag;
        logic [PRD_W-1:0] s;
        logic [PRD_W-1:0] t;
    } t_keep;

    logic r_vld [1:9];

    logic signed [DIF_W-1:0] r_dx, r_dy, r_dz, r_px, r_py, r_pz;
    logic signed [PRD_W-1:0] r_p_xx, r_p_yy, r_p_zz, r_p_dxpy, r_p_pxdy, r_p_dxpx, r_p_dypy;
    logic signed [DIF_W-1:0] r2_dz, r2_pz;
    logic [PRD_W-1:0] r3_s, r3_zz;
    logic [SUM_W-1:0] r3_hn, r3_a;
    logic signed [DIF_W-1:0] r3_dz, r3_pz;
    logic [PRD_W-1:0] r4_amag, r4_s;
    logic r4_aneg, r4_dzneg, r4_pzneg;
    logic [DIF_W-1:0] r4_dzm, r4_pzm;
    logic [PRD_W-1:0] r5_al, r5_ah, r5_sl, r5_sh;
    logic r5_n1neg, r5_cneg;
    logic [NSUM_W-2:0] r6_n1, r6_c;
    logic r6_n1neg, r6_cneg;
    logic [NSUM_W-1:0] r7_v1, r7_v2;
    logic [NSUM_W-1:0] r8_n;
    logic r9_nneg;
    logic [NMAG_W-1:0] r9_nmag;
    t_keep r_keep [4:9];

    logic [SUM_W-1:0] n_amag, n_hmag;
    logic [DIF_W-1:0] n_dzm, n_pzm;
    logic [NSUM_W-1:0] n_nmag;

    always_comb begin
        n_amag = r3_a[SUM_W-1]  ? (SUM_W'(0) - r3_a)  : r3_a;
        n_hmag = r3_hn[SUM_W-1] ? (SUM_W'(0) - r3_hn) : r3_hn;
        n_dzm  = r3_dz[DIF_W-1] ? (DIF_W'(0) - DIF_W'(r3_dz)) : DIF_W'(r3_dz);
        n_pzm  = r3_pz[DIF_W-1] ? (DIF_W'(0) - DIF_W'(r3_pz)) : DIF_W'(r3_pz);
        n_nmag = r8_n[NSUM_W-1] ? (NSUM_W'(0) - r8_n) : r8_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 9; k++) r_vld[k] <= 1'b0;
        end else if (i_en) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= 9; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx <= {i_end_x[CRD_W-1], i_end_x} - {i_start_x[CRD_W-1], i_start_x};
            r_dy <= {i_end_y[CRD_W-1], i_end_y} - {i_start_y[CRD_W-1], i_start_y};
            r_dz <= {i_end_z[CRD_W-1], i_end_z} - {i_start_z[CRD_W-1], i_start_z};
            r_px <= {i_pos_x[CRD_W-1], i_pos_x} - {i_start_x[CRD_W-1], i_start_x};
            r_py <= {i_pos_y[CRD_W-1], i_pos_y} - {i_start_y[CRD_W-1], i_start_y};
            r_pz <= {i_pos_z[CRD_W-1], i_pos_z} - {i_start_z[CRD_W-1], i_start_z};

            r_p_xx   <= r_dx * r_dx;
            r_p_yy   <= r_dy * r_dy;
            r_p_zz   <= r_dz * r_dz;
            r_p_dxpy <= r_dx * r_py;
            r_p_pxdy <= r_px * r_dy;
            r_p_dxpx <= r_dx * r_px;
            r_p_dypy <= r_dy * r_py;
            r2_dz    <= r_dz;
            r2_pz    <= r_pz;

            r3_s  <= r_p_xx + r_p_yy;
            r3_zz <= r_p_zz;
            r3_hn <= {r_p_dxpy[PRD_W-1], r_p_dxpy} - {r_p_pxdy[PRD_W-1], r_p_pxdy};
            r3_a  <= {r_p_dxpx[PRD_W-1], r_p_dxpx} + {r_p_dypy[PRD_W-1], r_p_dypy};
            r3_dz <= r2_dz;
            r3_pz <= r2_pz;

            r4_amag  <= n_amag[PRD_W-1:0];
            r4_aneg  <= r3_a[SUM_W-1];
            r4_s     <= r3_s;
            r4_dzm   <= n_dzm;
            r4_pzm   <= n_pzm;
            r4_dzneg <= r3_dz[DIF_W-1];
            r4_pzneg <= r3_pz[DIF_W-1];
            r_keep[4].degen <= (r3_s == '0);
            r_keep[4].h_neg <= r3_hn[SUM_W-1];
            r_keep[4].h_mag <= n_hmag[PRD_W-1:0];
            r_keep[4].s     <= r3_s;
            r_keep[4].t     <= r3_s + r3_zz;

            r5_al    <= r4_amag[DIF_W-1:0] * r4_dzm;
            r5_ah    <= r4_amag[PRD_W-1:DIF_W] * r4_dzm;
            r5_sl    <= r4_s[DIF_W-1:0] * r4_pzm;
            r5_sh    <= r4_s[PRD_W-1:DIF_W] * r4_pzm;
            r5_n1neg <= !(r4_dzneg ^ r4_aneg);
            r5_cneg  <= r4_pzneg;

            r6_n1    <= {r5_ah, {DIF_W{1'b0}}} + (NSUM_W-1)'(r5_al);
            r6_c     <= {r5_sh, {DIF_W{1'b0}}} + (NSUM_W-1)'(r5_sl);
            r6_n1neg <= r5_n1neg;
            r6_cneg  <= r5_cneg;

            r7_v1 <= r6_n1neg ? (NSUM_W'(0) - {1'b0, r6_n1}) : {1'b0, r6_n1};
            r7_v2 <= r6_cneg  ? (NSUM_W'(0) - {1'b0, r6_c})  : {1'b0, r6_c};

            r8_n <= r7_v1 + r7_v2;

            r9_nneg <= r8_n[NSUM_W-1];
            r9_nmag <= n_nmag[NMAG_W-1:0];

            for (int k = 5; k <= 9; k++) r_keep[k] <= r_keep[k-1];
        end
    end

    assign o_valid     = r_vld[9];
    assign o_geo.degen = r_keep[9].degen;
    assign o_geo.h_neg = r_keep[9].h_neg;
    assign o_geo.h_mag = r_keep[9].h_mag;
    assign o_geo.n_neg = r9_nneg;
    assign o_geo.n_mag = r9_nmag;
    assign o_s         = r_keep[9].s;
    assign o_t         = r_keep[9].t;

endmodule

// File: src/ctld_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module ctld_sqrt import ctld_pkg::*; #(
    parameter int RW = ROOT_W,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_side
);

    logic            r_valid [0:RW];
    logic [2*RW-1:0] r_rad   [0:RW];
    logic [RW+1:0]   r_rem   [0:RW];
    logic [RW-1:0]   r_root  [0:RW];
    logic [SW-1:0]   r_side  [0:RW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= RW; k++) begin : g_step
        logic [RW+3:0] n_sh;
        logic [RW+3:0] n_trial;
        logic [RW+3:0] n_dif;
        logic          n_ge;

        always_comb begin
            n_sh    = {r_rem[k-1], r_rad[k-1][2*RW-2*k+1 -: 2]};
            n_trial = {2'b00, r_root[k-1], 2'b01};
            n_ge    = (n_sh >= n_trial);
            n_dif   = n_sh - n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= r_rad[k-1];
                r_rem[k]  <= n_ge ? n_dif[RW+1:0] : n_sh[RW+1:0];
                r_root[k] <= {r_root[k-1][RW-2:0], n_ge};
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[RW];
    assign o_root  = r_root[RW];
    assign o_side  = r_side[RW];

endmodule

// File: src/ctld_div.sv
// Pipelined restoring divider with overflow detect, one quotient bit per stage.
`timescale 1ns / 1ps
module ctld_div import ctld_pkg::*; #(
    parameter int QW = HQ_W,
    parameter int VW = ROOT_W,
    parameter int SW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [VW-1:0] i_hi,
    input  logic [QW-1:0] i_lo,
    input  logic [VW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic          o_ovf,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_valid [0:QW];
    logic          r_ovf   [0:QW];
    logic [VW-1:0] r_rem   [0:QW];
    logic [QW-1:0] r_quo   [0:QW];
    logic [VW-1:0] r_den   [0:QW];
    logic [SW-1:0] r_side  [0:QW];

    logic n_ovf;
    assign n_ovf = (i_hi >= i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0]  <= n_ovf;
            r_rem[0]  <= n_ovf ? '0 : i_hi;
            r_quo[0]  <= i_lo;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [VW:0] n_sh;
        logic [VW:0] n_dif;
        logic        n_ge;

        always_comb begin
            n_sh  = {r_rem[k-1], r_quo[k-1][QW-1]};
            n_ge  = (n_sh >= {1'b0, r_den[k-1]});
            n_dif = n_sh - {1'b0, r_den[k-1]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_rem[k]  <= n_ge ? n_dif[VW-1:0] : n_sh[VW-1:0];
                r_quo[k]  <= {r_quo[k-1][QW-2:0], n_ge};
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_valid[QW];
    assign o_ovf   = r_ovf[QW];
    assign o_quo   = r_quo[QW];
    assign o_side  = r_side[QW];

endmodule

// File: src/cross_track_line_distance_unit.sv
// Top level of the cross-track distance unit: config registers, pipeline and output skid.
`timescale 1ns / 1ps
// Takes one position beat per cycle and returns one distance beat per position, in order.
// From input acceptance to o_m_tvalid a beat passes through 9 front stages (differences,
// products, numerators), 51 square-root stages for both line lengths, 68 stages for the first
// vertical division, 34 stages for the horizontal and second vertical division, and the output
// register. The whole pipeline holds while the output skid register is full; o_s_tready is low
// only then. Write the line end points over the cfg port only while no beat is in flight.
// o_m_tuser is the degenerate flag: set when the line has no horizontal length, and both
// distances are then zero.
module cross_track_line_distance_unit import ctld_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // pos_x, pos_y, pos_z
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // horiz_dist, vert_dist
    output logic                  o_m_tuser,   // degenerate
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CRD_W-1:0]      i_cfg_data
);

    logic [CRD_W-1:0] r_start_x, r_start_y, r_start_z, r_end_x, r_end_y, r_end_z;

    logic en;
    logic fr_valid;
    t_geo fr_geo;
    logic [PRD_W-1:0] fr_s, fr_t;

    logic lq_valid, lt_valid;
    logic [ROOT_W-1:0] lq_root, lt_root;
    t_geo lq_geo;
    logic lt_degen;

    t_vq_side vq_side_in, vq_side;
    logic vq_valid, vq_ovf;
    logic [VQ_W-1:0] vq_quo;

    t_tag hz_tag_in, hz_tag, vt_tag_in, vt_tag;
    logic hz_valid, hz_ovf, vt_valid, vt_ovf;
    logic [HQ_W-1:0] hz_quo, vt_quo;

    logic r_out_valid, r_skid_valid;
    logic [OUT_DATA_W-1:0] r_out_data, r_skid_data;
    logic r_out_user, r_skid_user;
    logic [OUT_DATA_W-1:0] n_data;
    logic take;

    function automatic logic [CRD_W-1:0] sat_dist(input logic neg, input logic ovf,
                                                  input logic [HQ_W-1:0] mag);
        logic [HQ_W-1:0] neg_mag;
        neg_mag = HQ_W'(0) - mag;
        if (neg) begin
            if (ovf || mag > {2'b01, {(HQ_W-2){1'b0}}}) return {1'b1, {(CRD_W-1){1'b0}}};
            return neg_mag[CRD_W-1:0];
        end
        if (ovf || mag[HQ_W-1] || mag[CRD_W-1]) return {1'b0, {(CRD_W-1){1'b1}}};
        return mag[CRD_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_z <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_end_z   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_X: r_start_x <= i_cfg_data;
                REG_START_Y: r_start_y <= i_cfg_data;
                REG_START_Z: r_start_z <= i_cfg_data;
                REG_END_X:   r_end_x   <= i_cfg_data;
                REG_END_Y:   r_end_y   <= i_cfg_data;
                REG_END_Z:   r_end_z   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign en         = !r_skid_valid;
    assign o_s_tready = en;

    ctld_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_s_tvalid && en),
        .i_pos_x   (i_s_tdata[CRD_W-1:0]),
        .i_pos_y   (i_s_tdata[2*CRD_W-1:CRD_W]),
        .i_pos_z   (i_s_tdata[3*CRD_W-1:2*CRD_W]),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .i_start_z (r_start_z),
        .i_end_x   (r_end_x),
        .i_end_y   (r_end_y),
        .i_end_z   (r_end_z),
        .o_valid   (fr_valid),
        .o_geo     (fr_geo),
        .o_s       (fr_s),
        .o_t       (fr_t)
    );

    ctld_sqrt #(.RW(ROOT_W), .SW($bits(t_geo))) u_sqrt_lq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_rad   ({2'b00, fr_s, {CRD_W{1'b0}}}),
        .i_side  (fr_geo),
        .o_valid (lq_valid),
        .o_root  (lq_root),
        .o_side  (lq_geo)
    );

    ctld_sqrt #(.RW(ROOT_W), .SW(1)) u_sqrt_lt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_rad   ({2'b00, fr_t, {CRD_W{1'b0}}}),
        .i_side  (fr_geo.degen),
        .o_valid (lt_valid),
        .o_root  (lt_root),
        .o_side  (lt_degen)
    );

    always_comb begin
        vq_side_in.degen = lq_geo.degen;
        vq_side_in.h_neg = lq_geo.h_neg;
        vq_side_in.h_mag = lq_geo.h_mag;
        vq_side_in.n_neg = lq_geo.n_neg;
        vq_side_in.lq    = lq_root;
        vq_side_in.lt    = lt_root;
    end

    ctld_div #(.QW(VQ_W), .VW(ROOT_W), .SW($bits(t_vq_side))) u_div_vq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lq_valid),
        .i_hi    (ROOT_W'(lq_geo.n_mag[NMAG_W-1:VQ_W-FRAC_W])),
        .i_lo    ({lq_geo.n_mag[VQ_W-FRAC_W-1:0], {FRAC_W{1'b0}}}),
        .i_den   (lq_root),
        .i_side  (vq_side_in),
        .o_valid (vq_valid),
        .o_ovf   (vq_ovf),
        .o_quo   (vq_quo),
        .o_side  (vq_side)
    );

    always_comb begin
        hz_tag_in.flag = vq_side.degen;
        hz_tag_in.neg  = vq_side.h_neg;
        vt_tag_in.flag = vq_ovf;
        vt_tag_in.neg  = vq_side.n_neg;
    end

    ctld_div #(.QW(HQ_W), .VW(ROOT_W), .SW($bits(t_tag))) u_div_hz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vq_valid),
        .i_hi    (ROOT_W'(vq_side.h_mag[PRD_W-1:HQ_W-FRAC_W])),
        .i_lo    ({vq_side.h_mag[HQ_W-FRAC_W-1:0], {FRAC_W{1'b0}}}),
        .i_den   (vq_side.lq),
        .i_side  (hz_tag_in),
        .o_valid (hz_valid),
        .o_ovf   (hz_ovf),
        .o_quo   (hz_quo),
        .o_side  (hz_tag)
    );

    ctld_div #(.QW(HQ_W), .VW(ROOT_W), .SW($bits(t_tag))) u_div_vt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vq_valid),
        .i_hi    (ROOT_W'(vq_quo[VQ_W-1:HQ_W-FRAC_W])),
        .i_lo    ({vq_quo[HQ_W-FRAC_W-1:0], {FRAC_W{1'b0}}}),
        .i_den   (vq_side.lt),
        .i_side  (vt_tag_in),
        .o_valid (vt_valid),
        .o_ovf   (vt_ovf),
        .o_quo   (vt_quo),
        .o_side  (vt_tag)
    );

    always_comb begin
        if (hz_tag.flag) begin
            n_data = '0;
        end else begin
            n_data = {sat_dist(vt_tag.neg, vt_ovf || vt_tag.flag, vt_quo),
                      sat_dist(hz_tag.neg, hz_ovf, hz_quo)};
        end
    end

    assign take = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_out_data   <= r_skid_data;
                r_out_user   <= r_skid_user;
                r_skid_valid <= 1'b0;
            end
        end else if (hz_valid) begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_data;
                r_out_user  <= hz_tag.flag;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid_data  <= n_data;
                r_skid_user  <= hz_tag.flag;
            end
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_sqrt_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lq_valid == lt_valid) else $error("root pipelines out of step");
    a_sqrt_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lq_valid |-> (lq_geo.degen == lt_degen)) else $error("root pipelines carry different beats");
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hz_valid == vt_valid) else $error("divider pipelines out of step");
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0)) else $error("degenerate beat not zero");
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid) else $error("skid holds a beat ahead of output");
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_m_tready) |=> !r_skid_valid) else $error("skid did not drain");

endmodule
